// ===== rtl/pts_pkg.sv =====
// pts_pkg: shared constants, opcodes and item/command types for the
// priority task scheduler. No dependencies.
package pts_pkg;

    localparam int TASK_SLOTS = 32;
    localparam int COUNT_BITS = 16;
    localparam int CFG_W      = 32;
    localparam int SLOT_W     = $clog2(TASK_SLOTS);
    localparam int IDX_W      = SLOT_W + 1;
    localparam logic [SLOT_W-1:0] IDLE_SLOT = SLOT_W'(TASK_SLOTS - 1);

    localparam logic [1:0] OP_START    = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_SLEEP    = 2'd2;
    localparam logic [1:0] OP_DISPATCH = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [4:0]  task_id;
        logic [15:0] sleep_ticks;
    } t_in_item;

    typedef struct packed {
        logic [4:0] current_task;
        logic [4:0] previous_task;
        logic       idle_selected;
        logic [7:0] idle_ticks;
        logic       error_flag;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic exec_simple;
        logic walk_begin;
        logic walk_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic walk_op;
        logic walk_done;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/pts_ctrl.sv =====
// pts_ctrl: sequencing state machine for the task scheduler.
// Depends on pts_pkg; drives pts_dp through command/status structs.
module pts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pts_pkg::t_dp_stat i_stat,
    output pts_pkg::t_dp_cmd  o_cmd
);
    import pts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_WALK   = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.walk_op) begin
                    o_cmd.walk_begin = 1'b1;
                    n_state          = S_WALK;
                end else begin
                    o_cmd.exec_simple = 1'b1;
                    n_state           = S_DONE;
                end
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted item not decoded");

    a_walk_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WALK) && !i_stat.walk_done) |=> (r_state == S_WALK))
        else $error("slot walk left early");

    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WALK) && i_stat.walk_done) |=> (r_state == S_DONE))
        else $error("slot walk did not finish");

endmodule

// ===== rtl/pts_dp.sv =====
// pts_dp: scheduler state, sleep counter memory, slot walker and result register.
// Depends on pts_pkg; controlled by pts_ctrl.
module pts_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [31:0]        i_cfg_data,
    input  pts_pkg::t_in_item  i_item,
    input  pts_pkg::t_dp_cmd   i_cmd,
    output pts_pkg::t_dp_stat  o_stat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pts_pkg::t_out_item o_out_item
);
    import pts_pkg::*;

    logic [CFG_W-1:0]      r_cfg;
    logic [1:0]            r_op;
    logic [4:0]            r_tid;
    logic [15:0]           r_ticks;
    logic [TASK_SLOTS-1:0] r_ready;
    logic [TASK_SLOTS-1:0] r_sleep;
    logic                  r_running;
    logic [SLOT_W-1:0]     r_selected;
    logic [SLOT_W-1:0]     r_prior;
    logic [7:0]            r_tick_count;
    logic                  r_err;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_found;
    logic [SLOT_W-1:0]     r_pick;
    logic [COUNT_BITS-1:0] r_rd_data;
    logic [COUNT_BITS-1:0] r_cnt_mem [TASK_SLOTS];
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic [TASK_SLOTS-1:0] users;
    logic                  proc_valid;
    logic [SLOT_W-1:0]     proc_slot;
    logic [COUNT_BITS-1:0] cnt_dec;
    logic                  tick_hit;
    logic                  wake;
    logic                  disp_hit;
    logic                  tid_bad;
    logic                  sleep_ok;
    logic                  start_ok;
    logic                  walk_done;
    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_wa;
    logic [COUNT_BITS-1:0] mem_wd;
    t_out_item             out_next;

    // registered user tasks, idle slot excluded
    assign users = TASK_SLOTS'(r_cfg) & ~(TASK_SLOTS'(1) << IDLE_SLOT);

    // walk stage two: slot idx-1 sees its counter read in the previous cycle
    assign proc_valid = i_cmd.walk_step && (r_idx != '0);
    assign proc_slot  = SLOT_W'(r_idx - IDX_W'(1));
    assign cnt_dec    = r_rd_data - COUNT_BITS'(1);
    assign tick_hit   = proc_valid && (r_op == OP_TICK) && r_sleep[proc_slot]
                        && users[proc_slot];
    assign wake       = tick_hit && (cnt_dec == '0);
    assign disp_hit   = proc_valid && (r_op == OP_DISPATCH) && r_ready[proc_slot]
                        && users[proc_slot] && !r_found;
    assign walk_done  = (r_idx == IDX_W'(TASK_SLOTS));

    assign tid_bad  = (32'(r_tid) >= 32'(TASK_SLOTS - 1)) || !users[SLOT_W'(r_tid)];
    assign sleep_ok = i_cmd.exec_simple && (r_op == OP_SLEEP) && !tid_bad;
    assign start_ok = i_cmd.exec_simple && (r_op == OP_START);

    assign mem_we = sleep_ok || tick_hit;
    assign mem_wa = sleep_ok ? SLOT_W'(r_tid) : proc_slot;
    assign mem_wd = sleep_ok ? COUNT_BITS'(r_ticks) : cnt_dec;

    assign o_stat.walk_op   = ((r_op == OP_TICK) || (r_op == OP_DISPATCH)) && r_running;
    assign o_stat.walk_done = walk_done;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_item.opcode;
            r_tid   <= i_item.task_id;
            r_ticks <= i_item.sleep_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_cnt_mem[mem_wa] <= mem_wd;
        end
        if (r_idx < IDX_W'(TASK_SLOTS)) begin
            r_rd_data <= r_cnt_mem[r_idx[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready   <= '0;
            r_sleep   <= '0;
            r_running <= 1'b0;
        end else if (start_ok) begin
            r_ready   <= r_ready | users;
            r_sleep   <= r_sleep & ~users;
            r_running <= 1'b1;
        end else if (sleep_ok) begin
            r_sleep[SLOT_W'(r_tid)] <= 1'b1;
            r_ready[SLOT_W'(r_tid)] <= 1'b0;
        end else if (wake) begin
            r_ready[proc_slot] <= 1'b1;
            r_sleep[proc_slot] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.walk_begin) begin
            r_idx   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.walk_step) begin
            if (!walk_done) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (disp_hit) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (disp_hit) begin
            r_pick <= proc_slot;
        end
    end

    // commit on the last walk cycle; the idle slot handled there is never a candidate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_selected   <= '0;
            r_prior      <= '0;
            r_tick_count <= '0;
        end else if (i_cmd.walk_step && walk_done) begin
            if (r_op == OP_TICK) begin
                r_tick_count <= r_tick_count + 8'd1;
            end else begin
                r_prior    <= r_selected;
                r_selected <= r_found ? r_pick : IDLE_SLOT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= 1'b0;
        end else if (i_cmd.exec_simple) begin
            r_err <= (r_op == OP_SLEEP) && tid_bad;
        end else if (i_cmd.walk_begin) begin
            r_err <= 1'b0;
        end
    end

    always_comb begin
        out_next.current_task  = 5'(r_selected);
        out_next.previous_task = 5'(r_prior);
        out_next.idle_selected = (r_selected == IDLE_SLOT);
        out_next.idle_ticks    = r_tick_count;
        out_next.error_flag    = r_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_item <= out_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_masks_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ready & r_sleep) == '0)
        else $error("task both ready and sleeping");

    a_idle_slot_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ready[IDLE_SLOT] && !r_sleep[IDLE_SLOT])
        else $error("idle slot entered ready or sleeping set");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("pending result overwritten");

endmodule

// ===== rtl/priority_task_scheduler.sv =====
// priority_task_scheduler: top level of the fixed-priority task scheduler.
// Depends on pts_pkg, pts_ctrl and pts_dp.
//
// Fixed-priority scheduler with sleep ticks: one result item per input item.
// Start, sleep, and a tick or dispatch issued before start each go from decode
// to the done state, which loads the result into the output register; the next
// item can be accepted once the controller is back in idle. A tick or dispatch
// while running walks every task slot through the sleep counter memory (one
// write port, one read port), one slot per cycle with a registered read, and
// then reaches the done state in the same way. A new item is accepted while the
// previous result still waits in the output register; a finished item whose
// result cannot yet be loaded holds there until the output register frees. The
// configuration write is always ready.
module priority_task_scheduler (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pts_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pts_pkg::t_out_item o_out_item
);
    import pts_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    pts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pts_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
